// ===== design/mdm_pkg.sv =====
// Package for the mecanum drive mixer: types, constants and divider step function.
package mdm_pkg;

   localparam int NUM_WHEELS = 4;
   localparam int DIV_STAGES = 8;
   localparam int LATENCY    = 4 + DIV_STAGES;

   localparam logic [16:0] ONE_Q15 = 17'd32768;

   localparam logic [14:0] STRAFE_DEADBAND_RESET       = 15'd9830;
   localparam logic [14:0] STRAFE_FULL_THRESHOLD_RESET = 15'd29491;
   localparam logic [14:0] STRAFE_STEP_LEVEL_RESET     = 15'd29491;
   localparam logic [14:0] FORWARD_DEADBAND_RESET      = 15'd3867;
   localparam logic [14:0] BUTTON_STRAFE_LEVEL_RESET   = 15'd26214;

   typedef enum logic [2:0] {
      CSR_STRAFE_DEADBAND       = 3'd0,
      CSR_STRAFE_FULL_THRESHOLD = 3'd1,
      CSR_STRAFE_STEP_LEVEL     = 3'd2,
      CSR_FORWARD_DEADBAND      = 3'd3,
      CSR_BUTTON_STRAFE_LEVEL   = 3'd4
   } csr_index_type;

   localparam int WHEEL_FL = 0;
   localparam int WHEEL_FR = 1;
   localparam int WHEEL_RL = 2;
   localparam int WHEEL_RR = 3;

   typedef struct packed {
      logic        valid;
      logic [16:0] strafe;
      logic [16:0] fwd;
      logic [16:0] rot;
   } cmd_stage_type;

   typedef struct packed {
      logic                             valid;
      logic [NUM_WHEELS-1:0][17:0]      sum;
   } sum_stage_type;

   typedef struct packed {
      logic [17:0] sum;
      logic [16:0] rem;
      logic [15:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                              valid;
      logic                              norm;
      logic [16:0]                       max;
      div_lane_type [NUM_WHEELS-1:0]     lane;
   } div_stage_type;

   typedef struct packed {
      logic        q_bit;
      logic [16:0] rem;
   } step_type;

   function automatic logic [16:0] mag18(logic [17:0] v);
      logic [17:0] n;
      n = ~v + 18'd1;
      return v[17] ? n[16:0] : v[16:0];
   endfunction

   function automatic step_type div_step(logic [16:0] rem, logic [16:0] divisor);
      step_type    res;
      logic [17:0] t;
      logic [17:0] d;
      t = {rem, 1'b0};
      d = {1'b0, divisor};
      if (t >= d) begin
         res.q_bit = 1'b1;
         res.rem   = 17'(t - d);
      end else begin
         res.q_bit = 1'b0;
         res.rem   = t[16:0];
      end
      return res;
   endfunction

endpackage

// ===== design/mecanum_drive_mixer_top.sv =====
// Mecanum drive mixer: joystick shaping, wheel mixing and pipelined normalization.
//
//  channel   ports                      handshake              payload
//  request   start / busy, req_*        start && !busy         x, y, twist, 4 buttons
//  response  rsp_valid, rsp_*           one-cycle strobe       four wheel drives, Q2.15
//  csr       csr_valid / csr_ready      valid && ready         csr_index, csr_data
//
//  Pipeline stages in order: shaping, mixing, max search, then 8 divider stages of two
//  quotient bits each, then sign and polarity.
//  One transaction is accepted every cycle; busy is high only during reset.
//  Synchronous reset clears all valid bits and restores the register defaults.
//  The receiver cannot stall, so the pipeline never holds.
module mecanum_drive_mixer_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_x_axis,
   input  logic signed [15:0] req_y_axis,
   input  logic signed [15:0] req_twist_axis,
   input  logic               req_rotate_enable,
   input  logic               req_forward_off,
   input  logic               req_strafe_left_button,
   input  logic               req_strafe_right_button,
   output logic               rsp_valid,
   output logic signed [16:0] rsp_lf_drive,
   output logic signed [16:0] rsp_rf_drive,
   output logic signed [16:0] rsp_lr_drive,
   output logic signed [16:0] rsp_rr_drive,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_data
);

   logic [14:0] strafe_deadband_ff;
   logic [14:0] strafe_full_threshold_ff;
   logic [14:0] strafe_step_level_ff;
   logic [14:0] forward_deadband_ff;
   logic [14:0] button_strafe_level_ff;

   mdm_pkg::cmd_stage_type cmd_ff, cmd_in;
   mdm_pkg::sum_stage_type sum_ff, sum_in;
   mdm_pkg::div_stage_type dv_head;
   mdm_pkg::div_stage_type dv_ff [mdm_pkg::DIV_STAGES+1];
   mdm_pkg::div_stage_type dv_in [mdm_pkg::DIV_STAGES+1];

   logic        rsp_valid_ff;
   logic [16:0] rsp_drive_ff [mdm_pkg::NUM_WHEELS];
   logic [16:0] rsp_drive_in [mdm_pkg::NUM_WHEELS];

   logic        accept;
   logic [16:0] x_ext, x_neg, x_mag;
   logic [16:0] y_ext, y_neg, y_mag;
   logic [16:0] step_pos, step_neg, button_pos, button_neg;
   logic [17:0] s18, f18, r18;
   logic [16:0] wheel_mag [mdm_pkg::NUM_WHEELS];
   logic [16:0] max_val;
   mdm_pkg::step_type st_a, st_b;
   logic        first_q;
   logic [16:0] first_rem;
   logic [16:0] q17, q17_neg, scaled, wheel_val;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         strafe_deadband_ff       <= mdm_pkg::STRAFE_DEADBAND_RESET;
         strafe_full_threshold_ff <= mdm_pkg::STRAFE_FULL_THRESHOLD_RESET;
         strafe_step_level_ff     <= mdm_pkg::STRAFE_STEP_LEVEL_RESET;
         forward_deadband_ff      <= mdm_pkg::FORWARD_DEADBAND_RESET;
         button_strafe_level_ff   <= mdm_pkg::BUTTON_STRAFE_LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (mdm_pkg::csr_index_type'(csr_index))
            mdm_pkg::CSR_STRAFE_DEADBAND:       strafe_deadband_ff       <= csr_data;
            mdm_pkg::CSR_STRAFE_FULL_THRESHOLD: strafe_full_threshold_ff <= csr_data;
            mdm_pkg::CSR_STRAFE_STEP_LEVEL:     strafe_step_level_ff     <= csr_data;
            mdm_pkg::CSR_FORWARD_DEADBAND:      forward_deadband_ff      <= csr_data;
            mdm_pkg::CSR_BUTTON_STRAFE_LEVEL:   button_strafe_level_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // shape strafe, forward and rotation
   always_comb begin
      x_ext      = {req_x_axis[15], req_x_axis};
      x_neg      = ~x_ext + 17'd1;
      x_mag      = x_ext[16] ? x_neg : x_ext;
      y_ext      = {req_y_axis[15], req_y_axis};
      y_neg      = ~y_ext + 17'd1;
      y_mag      = y_ext[16] ? y_neg : y_ext;
      step_pos   = {2'b00, strafe_step_level_ff};
      step_neg   = ~step_pos + 17'd1;
      button_pos = {2'b00, button_strafe_level_ff};
      button_neg = ~button_pos + 17'd1;

      cmd_in.valid = accept;
      if (x_mag < {2'b00, strafe_deadband_ff}) begin
         cmd_in.strafe = '0;
      end else if (x_mag < {2'b00, strafe_full_threshold_ff}) begin
         cmd_in.strafe = (!x_ext[16] && x_ext != '0) ? step_neg : step_pos;
      end else begin
         cmd_in.strafe = x_neg;
      end

      if (y_mag < {2'b00, forward_deadband_ff} || req_forward_off) begin
         cmd_in.fwd = '0;
      end else begin
         cmd_in.fwd = y_neg;
      end

      cmd_in.rot = req_rotate_enable ? {req_twist_axis[15], req_twist_axis} : '0;

      if (req_strafe_right_button) begin
         cmd_in.strafe = button_pos;
         cmd_in.fwd    = '0;
      end else if (req_strafe_left_button) begin
         cmd_in.strafe = button_neg;
         cmd_in.fwd    = '0;
      end
   end

   // mix into wheel sums
   always_comb begin
      s18 = {cmd_ff.strafe[16], cmd_ff.strafe};
      f18 = {cmd_ff.fwd[16], cmd_ff.fwd};
      r18 = {cmd_ff.rot[16], cmd_ff.rot};
      sum_in.valid                  = cmd_ff.valid;
      sum_in.sum[mdm_pkg::WHEEL_FL] = f18 - r18 + s18;
      sum_in.sum[mdm_pkg::WHEEL_FR] = f18 + r18 - s18;
      sum_in.sum[mdm_pkg::WHEEL_RL] = f18 - r18 - s18;
      sum_in.sum[mdm_pkg::WHEEL_RR] = f18 + r18 + s18;
   end

   // magnitudes and the largest one
   always_comb begin
      for (int i = 0; i < mdm_pkg::NUM_WHEELS; i++) begin
         wheel_mag[i] = mdm_pkg::mag18(sum_ff.sum[i]);
      end
      max_val = wheel_mag[0];
      for (int i = 1; i < mdm_pkg::NUM_WHEELS; i++) begin
         if (wheel_mag[i] > max_val) begin
            max_val = wheel_mag[i];
         end
      end
      dv_head.valid = sum_ff.valid;
      dv_head.max   = max_val;
      dv_head.norm  = max_val > mdm_pkg::ONE_Q15;
      for (int i = 0; i < mdm_pkg::NUM_WHEELS; i++) begin
         dv_head.lane[i].sum = sum_ff.sum[i];
         dv_head.lane[i].rem = wheel_mag[i];
         dv_head.lane[i].quo = '0;
      end
   end

   // divider: two quotient bits per stage
   always_comb begin
      st_a      = '0;
      st_b      = '0;
      first_q   = 1'b0;
      first_rem = '0;
      dv_in[0]  = dv_head;
      for (int k = 0; k < mdm_pkg::DIV_STAGES; k++) begin
         dv_in[k+1].valid = dv_ff[k].valid;
         dv_in[k+1].max   = dv_ff[k].max;
         dv_in[k+1].norm  = dv_ff[k].norm;
         for (int i = 0; i < mdm_pkg::NUM_WHEELS; i++) begin
            if (k == 0) begin
               first_q   = dv_ff[k].lane[i].rem >= dv_ff[k].max;
               first_rem = first_q ? 17'(dv_ff[k].lane[i].rem - dv_ff[k].max)
                                   : dv_ff[k].lane[i].rem;
               st_a.q_bit = first_q;
               st_a.rem   = first_rem;
            end else begin
               st_a = mdm_pkg::div_step(dv_ff[k].lane[i].rem, dv_ff[k].max);
            end
            st_b = mdm_pkg::div_step(st_a.rem, dv_ff[k].max);
            dv_in[k+1].lane[i].sum = dv_ff[k].lane[i].sum;
            dv_in[k+1].lane[i].rem = st_b.rem;
            dv_in[k+1].lane[i].quo = {dv_ff[k].lane[i].quo[13:0], st_a.q_bit, st_b.q_bit};
         end
      end
   end

   // restore sign, pick scaled or raw, flip right side
   always_comb begin
      q17       = '0;
      q17_neg   = '0;
      scaled    = '0;
      wheel_val = '0;
      for (int i = 0; i < mdm_pkg::NUM_WHEELS; i++) begin
         q17       = {1'b0, dv_ff[mdm_pkg::DIV_STAGES].lane[i].quo};
         q17_neg   = ~q17 + 17'd1;
         scaled    = dv_ff[mdm_pkg::DIV_STAGES].lane[i].sum[17] ? q17_neg : q17;
         wheel_val = dv_ff[mdm_pkg::DIV_STAGES].norm ? scaled
                                                     : dv_ff[mdm_pkg::DIV_STAGES].lane[i].sum[16:0];
         if (i == mdm_pkg::WHEEL_FR || i == mdm_pkg::WHEEL_RR) begin
            rsp_drive_in[i] = ~wheel_val + 17'd1;
         end else begin
            rsp_drive_in[i] = wheel_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid <= 1'b0;
         sum_ff.valid <= 1'b0;
         for (int k = 0; k <= mdm_pkg::DIV_STAGES; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff <= cmd_in;
         sum_ff <= sum_in;
         for (int k = 0; k <= mdm_pkg::DIV_STAGES; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         for (int i = 0; i < mdm_pkg::NUM_WHEELS; i++) begin
            rsp_drive_ff[i] <= rsp_drive_in[i];
         end
         rsp_valid_ff <= dv_ff[mdm_pkg::DIV_STAGES].valid;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lf_drive = $signed(rsp_drive_ff[mdm_pkg::WHEEL_FL]);
   assign rsp_rf_drive = $signed(rsp_drive_ff[mdm_pkg::WHEEL_FR]);
   assign rsp_lr_drive = $signed(rsp_drive_ff[mdm_pkg::WHEEL_RL]);
   assign rsp_rr_drive = $signed(rsp_drive_ff[mdm_pkg::WHEEL_RR]);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(mdm_pkg::LATENCY) rsp_valid)
      else $error("accepted transaction did not produce a response");

   a_rem_below_max: assert property (@(posedge clock) disable iff (reset)
      dv_ff[mdm_pkg::DIV_STAGES].valid && dv_ff[mdm_pkg::DIV_STAGES].norm |->
         dv_ff[mdm_pkg::DIV_STAGES].lane[mdm_pkg::WHEEL_FL].rem
            < dv_ff[mdm_pkg::DIV_STAGES].max)
      else $error("divider remainder not below divisor");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      dv_ff[mdm_pkg::DIV_STAGES].valid && dv_ff[mdm_pkg::DIV_STAGES].norm |->
         dv_ff[mdm_pkg::DIV_STAGES].lane[mdm_pkg::WHEEL_RR].quo <= 16'd32768)
      else $error("normalized quotient above one");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lf_drive >= -17'sd32768
                 && rsp_rr_drive >= -17'sd32768)
      else $error("drive command out of range");

endmodule
